FILE: rtl/core/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants of the DDA line rasterizer: command codes,
// request and result payloads, and the front-end sequencer states.
// ----------------------------------------------------------------------------
package dda_pkg;

  // coordinate width of endpoints and pixels
  localparam int COORD_BITS = 10;

  // command codes, also used as the kind of a queued operation
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // one request item
  typedef struct packed {
    logic                  command;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } dda_in_t;

  // one emitted pixel
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
  } dda_out_t;

  // front-end sequencer states
  typedef enum logic [1:0] {
    FS_IDLE,
    FS_PREP,
    FS_DIVIDE,
    FS_ISSUE
  } front_state_t;

endpackage

FILE: rtl/core/dda_div.sv
// ----------------------------------------------------------------------------
// dda_div
// Two-lane restoring divider for the per-axis increments. Each lane forms
// (num << FRAC_BITS) / den one quotient bit per cycle, num <= den, and
// applies the sign at the end, giving truncation toward zero.
// ----------------------------------------------------------------------------
module dda_div import dda_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [1:0][COORD_BITS-1:0]       num,
  input  logic [COORD_BITS-1:0]            den,
  input  logic [1:0]                       neg,
  output logic                             busy,
  output logic [1:0][FRAC_BITS+1:0]        inc
);

  localparam int CntW = $clog2(FRAC_BITS + 2);

  logic [CntW-1:0]       cnt;
  logic [COORD_BITS:0]   rem  [2];
  logic [COORD_BITS:0]   diff [2];
  logic [1:0]            ge;
  logic [FRAC_BITS:0]    quo  [2];
  logic [1:0]            sign;

  assign busy = (cnt != '0);

  // bit counter: one integer bit plus FRAC_BITS fraction bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CntW'(FRAC_BITS + 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // trial subtract per lane
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      diff[l] = rem[l] - {1'b0, den};
      ge[l]   = (rem[l] >= {1'b0, den});
    end
  end

  // partial remainder and quotient shift
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      if (start) begin
        rem[l]  <= {1'b0, num[l]};
        quo[l]  <= '0;
        sign[l] <= neg[l];
      end else if (busy) begin
        quo[l] <= {quo[l][FRAC_BITS-1:0], ge[l]};
        rem[l] <= ge[l] ? {diff[l][COORD_BITS-1:0], 1'b0}
                        : {rem[l][COORD_BITS-1:0], 1'b0};
      end
    end
  end

  // signed increments
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      inc[l] = sign[l] ? -{1'b0, quo[l]} : {1'b0, quo[l]};
    end
  end

endmodule

FILE: rtl/core/dda_fifo.sv
// ----------------------------------------------------------------------------
// dda_fifo
// Small operation queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dda_fifo import dda_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // fill count bounded by depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue count beyond depth");

  // a lone transfer in raises the count by one
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not grow on push");

endmodule

FILE: rtl/core/dda_front.sv
// ----------------------------------------------------------------------------
// dda_front
// Front end: accepts requests, passes step commands straight to the queue,
// and turns a load into step count and increments before queuing it.
// ----------------------------------------------------------------------------
module dda_front import dda_pkg::*; #(
  parameter  int FRAC_BITS = 16,
  localparam int OpW       = 3*COORD_BITS + 2*FRAC_BITS + 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dda_in_t        request,
  output logic           full,
  output logic           q_push,
  output logic [OpW-1:0] q_data,
  input  logic           q_full
);

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS:0]   steps;
    logic [FRAC_BITS+1:0]  inc_x;
    logic [FRAC_BITS+1:0]  inc_y;
  } op_t;

  front_state_t state, state_next;

  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [COORD_BITS:0]   steps;
  logic [COORD_BITS:0]   dx, dy, dx_neg, dy_neg;
  logic [COORD_BITS-1:0] mag_x, mag_y, step_w;
  logic                  accept;
  logic                  div_start;
  logic                  div_busy;
  logic [1:0][FRAC_BITS+1:0] div_inc;
  op_t                   op;

  assign accept = push && !full;

  // deltas, magnitudes and step count of the latched line
  always_comb begin
    dx     = {1'b0, ex} - {1'b0, sx};
    dy     = {1'b0, ey} - {1'b0, sy};
    dx_neg = -dx;
    dy_neg = -dy;
    mag_x  = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    mag_y  = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    step_w = (mag_y > mag_x) ? mag_y : mag_x;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      FS_IDLE: begin
        if (accept && request.command == CMD_LOAD) begin
          state_next = FS_PREP;
        end
      end
      FS_PREP: begin
        state_next = (step_w == '0) ? FS_ISSUE : FS_DIVIDE;
      end
      FS_DIVIDE: begin
        if (!div_busy) begin
          state_next = FS_ISSUE;
        end
      end
      FS_ISSUE: begin
        if (!q_full) begin
          state_next = FS_IDLE;
        end
      end
      default: state_next = FS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full      = (state != FS_IDLE) || q_full;
    div_start = 1'b0;
    q_push    = 1'b0;
    op        = '0;
    case (state)
      FS_IDLE: begin
        q_push  = accept && request.command == CMD_STEP;
        op.kind = CMD_STEP;
      end
      FS_PREP: begin
        div_start = (step_w != '0);
      end
      FS_ISSUE: begin
        q_push     = !q_full;
        op.kind    = CMD_LOAD;
        op.start_x = sx;
        op.start_y = sy;
        op.steps   = steps;
        op.inc_x   = (steps == '0) ? '0 : div_inc[0];
        op.inc_y   = (steps == '0) ? '0 : div_inc[1];
      end
      default: begin
      end
    endcase
  end

  assign q_data = op;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // endpoint and step count latches
  always_ff @(posedge clk) begin
    if (state == FS_IDLE && accept && request.command == CMD_LOAD) begin
      sx <= request.start_x;
      sy <= request.start_y;
      ex <= request.end_x;
      ey <= request.end_y;
    end
    if (state == FS_PREP) begin
      steps <= {1'b0, step_w};
    end
  end

  // increment divider
  dda_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({mag_y, mag_x}),
    .den   (step_w),
    .neg   ({dy[COORD_BITS], dx[COORD_BITS]}),
    .busy  (div_busy),
    .inc   (div_inc)
  );

endmodule

FILE: rtl/core/dda_back.sv
// ----------------------------------------------------------------------------
// dda_back
// Back end: holds the active line, applies queued loads, and for each step
// of an active line emits the floor of its position into the result register.
// ----------------------------------------------------------------------------
module dda_back import dda_pkg::*; #(
  parameter  int FRAC_BITS = 16,
  localparam int OpW       = 3*COORD_BITS + 2*FRAC_BITS + 6,
  localparam int PosW      = COORD_BITS + FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           op_valid,
  input  logic [OpW-1:0] op_data,
  output logic           op_pop,
  input  logic           pop,
  output logic           empty,
  output dda_out_t       result
);

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS:0]   steps;
    logic [FRAC_BITS+1:0]  inc_x;
    logic [FRAC_BITS+1:0]  inc_y;
  } op_t;

  op_t                  op;
  logic [PosW-1:0]      pos_x, pos_y;
  logic [FRAC_BITS+1:0] inc_x, inc_y;
  logic [PosW-1:0]      ext_x, ext_y;
  logic [COORD_BITS:0]  remaining;
  logic                 out_valid;
  dda_out_t             out_reg;
  logic                 out_ready;
  logic                 is_load;
  logic                 emit;

  assign op        = op_data;
  assign is_load   = (op.kind == CMD_LOAD);
  assign out_ready = !out_valid || pop;
  assign emit      = op_valid && !is_load && (remaining != '0) && out_ready;
  // steps on an idle line are dropped without waiting for output space
  assign op_pop    = op_valid && (is_load || remaining == '0 || out_ready);
  assign empty     = !out_valid;
  assign result    = out_reg;

  // sign-extended increments
  assign ext_x = {{(PosW-FRAC_BITS-2){inc_x[FRAC_BITS+1]}}, inc_x};
  assign ext_y = {{(PosW-FRAC_BITS-2){inc_y[FRAC_BITS+1]}}, inc_y};

  // line state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= '0;
      pos_y     <= '0;
      inc_x     <= '0;
      inc_y     <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      if (op_pop && is_load) begin
        pos_x     <= {op.start_x, {FRAC_BITS{1'b0}}};
        pos_y     <= {op.start_y, {FRAC_BITS{1'b0}}};
        inc_x     <= op.inc_x;
        inc_y     <= op.inc_y;
        remaining <= op.steps;
      end else if (emit) begin
        pos_x     <= pos_x + ext_x;
        pos_y     <= pos_y + ext_y;
        remaining <= remaining - 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_reg.pixel_x    <= pos_x[PosW-1:FRAC_BITS];
      out_reg.pixel_y    <= pos_y[PosW-1:FRAC_BITS];
      out_reg.last_pixel <= (remaining == (COORD_BITS+1)'(1));
    end
  end

  // pixel count never exceeds the widest line
  a_remaining_range: assert property (@(posedge clk) disable iff (rst)
    !remaining[COORD_BITS])
    else $error("pixel count out of range");

  // an emitted pixel shows up on the result side
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> !empty)
    else $error("emitted pixel not presented");

  // a step leaves without a pixel only when no line is active
  a_drop_idle: assert property (@(posedge clk) disable iff (rst)
    (op_pop && !is_load && !emit) |-> (remaining == '0))
    else $error("step dropped on an active line");

endmodule

FILE: rtl/core/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: a load latches a line and computes its fixed-point
// increments, each step on an active line emits the next pixel of the run.
//
//   channel   handshake            payload     direction
//   request   push / full          dda_in_t    in
//   result    empty / pop          dda_out_t   out
//
// A step passes the front end to the queue in the cycle it is accepted;
// pixels leave one per cycle while the result side keeps popping. A load holds
// full through step count, divider run, divider done and queue write; a zero-length load skips the divider.
// Steps queued before a load keep draining in the back end meanwhile.
// Reset (rst, synchronous) leaves no line active, the operation queue empty and no result pending.
// A stalled result side fills the operation queue, then raises full.
// ----------------------------------------------------------------------------
module dda_line_rasterizer import dda_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  dda_in_t  request,
  output logic     empty,
  input  logic     pop,
  output dda_out_t result
);

  localparam int OpW = 3*COORD_BITS + 2*FRAC_BITS + 6;

  logic           q_push;
  logic [OpW-1:0] q_wdata;
  logic           q_full;
  logic           q_pop;
  logic [OpW-1:0] q_rdata;
  logic           q_empty;

  // request decode and increment computation
  dda_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .request (request),
    .full    (full),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  // operation queue
  dda_fifo #(
    .WIDTH (OpW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // line stepping and pixel output
  dda_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (!q_empty),
    .op_data  (q_rdata),
    .op_pop   (q_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

endmodule
